### rtl/mrlp_pkg.sv
package mrlp_pkg;

  localparam logic [7:0] REPLY_VERSION = 8'h05;
  localparam logic [7:0] CMD_STATUS_A  = 8'h00;
  localparam logic [7:0] CMD_USERS     = 8'h01;
  localparam logic [7:0] CMD_METRICS   = 8'h02;
  localparam logic [7:0] CMD_STATUS_B  = 8'h03;
  localparam logic [7:0] STATUS_OK     = 8'h00;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_COMMAND  = 4'd1,
    PH_STATUS   = 4'd2,
    PH_COUNT    = 4'd3,
    PH_NAME     = 4'd4,
    PH_PASS     = 4'd5,
    PH_TOTAL    = 4'd6,
    PH_ACTIVE   = 4'd7,
    PH_BYTES    = 4'd8,
    PH_DONE     = 4'd9,
    PH_ERR_VER  = 4'd10,
    PH_ERR_CMD  = 4'd11,
    PH_ERR_NOCH = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_NAME   = 3'd1,
    KIND_PASS   = 3'd2,
    KIND_TOTAL  = 3'd3,
    KIND_ACTIVE = 3'd4,
    KIND_BYTES  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [3:0] parse_state_code;
    logic       data_valid;
    kind_t      data_kind;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] byte_position;
    logic       field_last;
    logic       finished;
    logic       error_flag;
  } res_t;

endpackage

### rtl/mgmt_reply_length_prefixed_parser_core.sv
// management reply parser, one reply byte per transfer
//
// input channel: in_valid / in_stall with in_rx_byte, one byte of the reply
// stream per transfer. result channel: out_valid / out_stall with one result
// per input byte: the parser state after the byte and, on a field data byte,
// its kind, value, user pair number, position in the field and a last flag.
//
// a byte's result is registered in the result register, or in the skid entry
// while a stalled result waits. throughput is one byte per cycle while in_stall
// is low; parse state, field and pair counters update when the byte is taken.
//
// the result register is backed by a one-entry skid register, so in_stall is
// a registered signal: a byte can still be taken while a result waits, and
// in_stall rises only once the skid entry is occupied by a stalled result.
//
// reset (rst_n low, synchronous) returns the parser to the version phase,
// clears all counters and empties both result registers. after done or an
// error the parser holds that state and ignores bytes until reset.
module mgmt_reply_length_prefixed_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_parse_state_code,
  output logic                          out_data_valid,
  output logic [2:0]                    out_data_kind,
  output logic [7:0]                    out_data_byte,
  output logic [7:0]                    out_entry_index,
  output logic [7:0]                    out_byte_position,
  output logic                          out_field_last,
  output logic                          out_finished,
  output logic                          out_error_flag
);
  import mrlp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] field_offset_r, field_offset_nxt;
  logic [7:0] pairs_left_r, pairs_left_nxt;
  logic [7:0] pair_number_r, pair_number_nxt;

  logic       out_valid_r, skid_valid_r;
  res_t       out_res_r, skid_res_r;
  res_t       res;

  logic       in_take;
  logic       out_free;
  logic       field_phase;
  logic       is_data;
  logic       is_last;
  kind_t      kind;

  assign in_take  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    field_phase = (phase_r == PH_NAME) || (phase_r == PH_PASS) ||
                  (phase_r == PH_TOTAL) || (phase_r == PH_ACTIVE) ||
                  (phase_r == PH_BYTES);
    is_data = field_phase && (bytes_left_r != 8'd0);
    is_last = is_data && (bytes_left_r == 8'd1);
  end

  // next state and counters
  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    field_offset_nxt = field_offset_r;
    pairs_left_nxt   = pairs_left_r;
    pair_number_nxt  = pair_number_r;

    if (field_phase) begin
      if (bytes_left_r == 8'd0) begin
        // length byte, zero means read another length
        bytes_left_nxt = in_rx_byte;
      end else if (is_last) begin
        bytes_left_nxt   = 8'd0;
        field_offset_nxt = 8'd0;
      end else begin
        bytes_left_nxt   = bytes_left_r - 8'd1;
        field_offset_nxt = field_offset_r + 8'd1;
      end
    end

    unique case (phase_r)
      PH_VERSION: begin
        phase_nxt = (in_rx_byte == REPLY_VERSION) ? PH_COMMAND : PH_ERR_VER;
      end
      PH_COMMAND: begin
        priority if (in_rx_byte == CMD_STATUS_A || in_rx_byte == CMD_STATUS_B)
          phase_nxt = PH_STATUS;
        else if (in_rx_byte == CMD_USERS)
          phase_nxt = PH_COUNT;
        else if (in_rx_byte == CMD_METRICS)
          phase_nxt = PH_TOTAL;
        else
          phase_nxt = PH_ERR_CMD;
      end
      PH_STATUS: begin
        phase_nxt = (in_rx_byte == STATUS_OK) ? PH_DONE : PH_ERR_NOCH;
      end
      PH_COUNT: begin
        pairs_left_nxt = in_rx_byte;
        phase_nxt      = PH_NAME;
      end
      PH_NAME: begin
        if (is_last) phase_nxt = PH_PASS;
      end
      PH_PASS: begin
        if (is_last) begin
          pair_number_nxt = pair_number_r + 8'd1;
          pairs_left_nxt  = pairs_left_r - 8'd1;
          // a count of zero wraps to 256 pairs
          phase_nxt = (pairs_left_r == 8'd1) ? PH_DONE : PH_NAME;
        end
      end
      PH_TOTAL: begin
        if (is_last) phase_nxt = PH_ACTIVE;
      end
      PH_ACTIVE: begin
        if (is_last) phase_nxt = PH_BYTES;
      end
      PH_BYTES: begin
        if (is_last) phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // result for the byte being taken
  always_comb begin
    unique case (phase_r)
      PH_NAME:   kind = KIND_NAME;
      PH_PASS:   kind = KIND_PASS;
      PH_TOTAL:  kind = KIND_TOTAL;
      PH_ACTIVE: kind = KIND_ACTIVE;
      PH_BYTES:  kind = KIND_BYTES;
      default:   kind = KIND_NONE;
    endcase

    res.parse_state_code = phase_nxt;
    res.data_valid       = is_data;
    res.data_kind        = is_data ? kind : KIND_NONE;
    res.data_byte        = is_data ? in_rx_byte : 8'd0;
    res.entry_index      = (is_data && (phase_r == PH_NAME || phase_r == PH_PASS)) ?
                           pair_number_r : 8'd0;
    res.byte_position    = is_data ? field_offset_r : 8'd0;
    res.field_last       = is_last;
    res.finished         = (phase_nxt >= PH_DONE);
    res.error_flag       = (phase_nxt >= PH_ERR_VER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_VERSION;
      bytes_left_r   <= 8'd0;
      field_offset_r <= 8'd0;
      pairs_left_r   <= 8'd0;
      pair_number_r  <= 8'd0;
    end else if (in_take) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      field_offset_r <= field_offset_nxt;
      pairs_left_r   <= pairs_left_nxt;
      pair_number_r  <= pair_number_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_take;
      skid_valid_r <= 1'b0;
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (in_take) begin
      skid_res_r <= res;
    end
  end

  assign in_stall             = skid_valid_r;
  assign out_valid            = out_valid_r;
  assign out_parse_state_code = out_res_r.parse_state_code;
  assign out_data_valid       = out_res_r.data_valid;
  assign out_data_kind        = out_res_r.data_kind;
  assign out_data_byte        = out_res_r.data_byte;
  assign out_entry_index      = out_res_r.entry_index;
  assign out_byte_position    = out_res_r.byte_position;
  assign out_field_last       = out_res_r.field_last;
  assign out_finished         = out_res_r.finished;
  assign out_error_flag       = out_res_r.error_flag;

endmodule

### bench/tb_mgmt_reply_length_prefixed_parser_core.sv
`timescale 1ns / 1ps

module tb_mgmt_reply_length_prefixed_parser_core;
  import mrlp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int LONG_HOLD_AT = 300;

  typedef enum logic [1:0] {
    STEP_LEN  = 2'd0,
    STEP_DATA = 2'd1,
    STEP_LAST = 2'd2
  } field_step_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_parse_state_code;
  logic       out_data_valid;
  logic [2:0] out_data_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_entry_index;
  logic [7:0] out_byte_position;
  logic       out_field_last;
  logic       out_finished;
  logic       out_error_flag;

  // predictor state
  phase_t     phase_q;
  logic [7:0] left_q;
  logic [7:0] offset_q;
  logic [7:0] pairs_q;
  logic [7:0] pair_no_q;

  stim_row_t  dir_table[$];
  logic [7:0] random_bytes[$];
  res_t       expected_results[$];
  res_t       want;
  int         mismatch_count = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  bit         send_quiet = 1'b0;

  mgmt_reply_length_prefixed_parser_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_parse_state_code (out_parse_state_code),
    .out_data_valid       (out_data_valid),
    .out_data_kind        (out_data_kind),
    .out_data_byte        (out_data_byte),
    .out_entry_index      (out_entry_index),
    .out_byte_position    (out_byte_position),
    .out_field_last       (out_field_last),
    .out_finished         (out_finished),
    .out_error_flag       (out_error_flag)
  );

  always #5 clk = ~clk;

  // one byte of a length-prefixed field
  function automatic field_step_t field_step(input logic [7:0] b, output logic [7:0] pos);
    pos = 8'h00;
    if (left_q == 8'h00) begin
      left_q = b;
      return STEP_LEN;
    end
    pos = offset_q;
    if (left_q == 8'h01) begin
      left_q = 8'h00;
      offset_q = 8'h00;
      return STEP_LAST;
    end
    left_q = left_q - 8'h01;
    offset_q = offset_q + 8'h01;
    return STEP_DATA;
  endfunction

  function automatic res_t predict_reply_byte(input logic [7:0] b);
    res_t        r;
    kind_t       kind;
    logic [7:0]  pos;
    logic [7:0]  idx;
    field_step_t st;
    kind = KIND_NONE;
    pos = 8'h00;
    idx = 8'h00;
    st = STEP_LEN;
    case (phase_q)
      PH_VERSION: phase_q = (b == REPLY_VERSION) ? PH_COMMAND : PH_ERR_VER;
      PH_COMMAND: begin
        if (b == CMD_STATUS_A || b == CMD_STATUS_B) phase_q = PH_STATUS;
        else if (b == CMD_USERS) phase_q = PH_COUNT;
        else if (b == CMD_METRICS) phase_q = PH_TOTAL;
        else phase_q = PH_ERR_CMD;
      end
      PH_STATUS: phase_q = (b == STATUS_OK) ? PH_DONE : PH_ERR_NOCH;
      PH_COUNT: begin
        pairs_q = b;
        phase_q = PH_NAME;
      end
      PH_NAME: begin
        idx = pair_no_q;
        st = field_step(b, pos);
        if (st != STEP_LEN) kind = KIND_NAME;
        if (st == STEP_LAST) phase_q = PH_PASS;
      end
      PH_PASS: begin
        idx = pair_no_q;
        st = field_step(b, pos);
        if (st != STEP_LEN) kind = KIND_PASS;
        if (st == STEP_LAST) begin
          pair_no_q = pair_no_q + 8'h01;
          pairs_q = pairs_q - 8'h01;
          phase_q = (pairs_q == 8'h00) ? PH_DONE : PH_NAME;
        end
      end
      PH_TOTAL: begin
        st = field_step(b, pos);
        if (st != STEP_LEN) kind = KIND_TOTAL;
        if (st == STEP_LAST) phase_q = PH_ACTIVE;
      end
      PH_ACTIVE: begin
        st = field_step(b, pos);
        if (st != STEP_LEN) kind = KIND_ACTIVE;
        if (st == STEP_LAST) phase_q = PH_BYTES;
      end
      PH_BYTES: begin
        st = field_step(b, pos);
        if (st != STEP_LEN) kind = KIND_BYTES;
        if (st == STEP_LAST) phase_q = PH_DONE;
      end
      default: ;
    endcase
    if (kind == KIND_NONE) begin
      pos = 8'h00;
      idx = 8'h00;
    end
    r.parse_state_code = phase_q;
    r.data_valid = (kind != KIND_NONE);
    r.data_kind = kind;
    r.data_byte = (kind != KIND_NONE) ? b : 8'h00;
    r.entry_index = idx;
    r.byte_position = pos;
    r.field_last = (st == STEP_LAST);
    r.finished = (phase_q >= PH_DONE);
    r.error_flag = (phase_q >= PH_ERR_VER);
    return r;
  endfunction

  // header bytes: no data, not finished
  function automatic res_t control_result(input phase_t ph);
    res_t r;
    r = '0;
    r.parse_state_code = ph;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    mismatch_count++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, exp_val);
  endtask

  task automatic send_byte(input stim_row_t row);
    int   gap;
    res_t predicted;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= row.rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_reply_byte(row.rx);
    expected_results.push_back(row.typed ? row.want : predicted);
  endtask

  // user list reply: count 0 wraps to 256 pairs, random field lengths
  task automatic build_user_list;
    int big_pair;
    int len;
    big_pair = $urandom_range(20, 230);
    for (int p = 2; p < 256; p++) begin
      for (int f = 0; f < 2; f++) begin
        if ($urandom_range(0, 9) == 0) random_bytes.push_back(8'h00);
        if (p == big_pair && f == 0) len = 255;
        else if ($urandom_range(0, 9) < 7) len = 1;
        else len = $urandom_range(2, 3);
        random_bytes.push_back(len[7:0]);
        repeat (len) random_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // parser is done now, these must be ignored
    repeat (16) random_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    phase_q = PH_VERSION;
    left_q = 8'h00;
    offset_q = 8'h00;
    pairs_q = 8'h00;
    pair_no_q = 8'h00;

    dir_table.push_back('{REPLY_VERSION, 1'b1, control_result(PH_COMMAND)});
    dir_table.push_back('{CMD_USERS, 1'b1, control_result(PH_COUNT)});
    dir_table.push_back('{8'h00, 1'b1, control_result(PH_NAME)});
    // zero length, the next byte is a length again
    dir_table.push_back('{8'h00, 1'b1, control_result(PH_NAME)});
    dir_table.push_back('{8'h01, 1'b1, control_result(PH_NAME)});
    dir_table.push_back('{8'hFF, 1'b1,
        '{PH_PASS, 1'b1, KIND_NAME, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0}});
    dir_table.push_back('{8'h00, 1'b1, control_result(PH_PASS)});
    dir_table.push_back('{8'h03, 1'b0, '0});
    dir_table.push_back('{8'h00, 1'b0, '0});
    dir_table.push_back('{8'h80, 1'b0, '0});
    dir_table.push_back('{8'h7F, 1'b0, '0});
    dir_table.push_back('{8'h02, 1'b0, '0});
    dir_table.push_back('{8'h55, 1'b0, '0});
    dir_table.push_back('{8'hAA, 1'b0, '0});
    dir_table.push_back('{8'h01, 1'b0, '0});
    dir_table.push_back('{8'h01, 1'b0, '0});
    build_user_list();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) send_byte(dir_table[i]);
    foreach (random_bytes[i]) begin
      if (i == random_bytes.size() / 2) begin
        // let the pipeline run dry before carrying on
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      send_byte('{random_bytes[i], 1'b0, '0});
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_mgmt_reply_length_prefixed_parser_core passed");
    else
      $display("tb_mgmt_reply_length_prefixed_parser_core failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    int  hold;
    bit  quiet;
    bit  long_done;
    quiet = 1'b0;
    long_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      hold = quiet ? 0 : $urandom_range(0, 11);
      if (!long_done && results_seen >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        hold = LONG_HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("transfer with nothing expected", out_parse_state_code, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_parse_state_code !== want.parse_state_code)
          report_mismatch("parse_state_code", out_parse_state_code, want.parse_state_code);
        if (out_data_valid !== want.data_valid)
          report_mismatch("data_valid", out_data_valid, want.data_valid);
        if (out_data_kind !== want.data_kind)
          report_mismatch("data_kind", out_data_kind, want.data_kind);
        if (out_data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_entry_index !== want.entry_index)
          report_mismatch("entry_index", out_entry_index, want.entry_index);
        if (out_byte_position !== want.byte_position)
          report_mismatch("byte_position", out_byte_position, want.byte_position);
        if (out_field_last !== want.field_last)
          report_mismatch("field_last", out_field_last, want.field_last);
        if (out_finished !== want.finished)
          report_mismatch("finished", out_finished, want.finished);
        if (out_error_flag !== want.error_flag)
          report_mismatch("error_flag", out_error_flag, want.error_flag);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("tb_mgmt_reply_length_prefixed_parser_core failed");
      $finish;
    end
  end

endmodule
